>>> rtl/core/amr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg
// Shared constants and types of the adaptive Morse receiver core.
// ----------------------------------------------------------------------------
package amr_pkg;

    // Symbols in one character before the code is thrown away
    localparam int SYMBOL_LIMIT = 16;
    // Characters in one word before a word end is forced
    localparam int WORD_LIMIT   = 32;

    localparam int SAMPLE_W     = 12;
    localparam int TIME_W       = 32;
    localparam int DIT_CFG_W    = 20;
    localparam int CHAR_W       = 7;
    localparam int CODE_W       = 16;
    localparam int SYM_CNT_W    = $clog2(SYMBOL_LIMIT + 2);
    localparam int WORD_CNT_W   = $clog2(WORD_LIMIT + 2);

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Register select, taken from paddr bit 2
    localparam logic REG_LEVEL_THRESHOLD = 1'b0;
    localparam logic REG_INITIAL_DIT     = 1'b1;

    localparam logic [SAMPLE_W-1:0]  LEVEL_THRESHOLD_RST = SAMPLE_W'(40);
    localparam logic [DIT_CFG_W-1:0] INITIAL_DIT_RST     = DIT_CFG_W'(100);

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  level_threshold;
        logic [DIT_CFG_W-1:0] initial_dit_us;
        logic                 dit_load;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              unknown;
        logic              word_end;
    } t_result;

endpackage

>>> rtl/core/adaptive_morse_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_morse_receiver_core
// Adaptive Morse receiver: raw level samples in (thresholded inside), decoded characters out.
// ----------------------------------------------------------------------------
// Accepts one timestamped sample item per clock and sustains that rate for as
// long as finished characters are taken. An accepted item is held in an input
// register, then decoded by the decoder, whose state update (level, last edge
// time, dit estimate, code, counters) is a registered loop that sets the rate;
// a character, if the item ends one, passes from the input register through
// the decoder into the output register. The output register decouples the
// sides: a new sample is still taken while a finished character waits, and
// the pipe only stalls when a character waits and the decoder has another
// item to finish. Items that cause no level change or only build up the
// current character give no output.
// Registers: level_threshold at byte address 0, initial_dit_us at byte address
// 4 (writing it also reloads the dit estimate); write them only while the block
// is idle.
// ----------------------------------------------------------------------------
module adaptive_morse_receiver_core import amr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // [11:0] sample, [43:12] time_us, rest zero
    // character stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [6:0] character, [7] zero
    output logic [1:0]            m_tuser,   // [0] unknown, [1] word_end
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SAMPLE_W-1:0]  r_level_threshold;
    logic [DIT_CFG_W-1:0] r_initial_dit;
    logic                 cfg_wr;
    t_cfg                 cfg;

    logic                 r_in_valid;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [TIME_W-1:0]    r_time_us;
    logic                 advance;

    logic                 res_valid;
    t_result              res;
    logic                 r_out_valid;
    t_result              r_out;

    // Configuration: writes complete in the access phase, never wait
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_threshold <= LEVEL_THRESHOLD_RST;
            r_initial_dit     <= INITIAL_DIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LEVEL_THRESHOLD: r_level_threshold <= pwdata[SAMPLE_W-1:0];
                REG_INITIAL_DIT:     r_initial_dit     <= pwdata[DIT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LEVEL_THRESHOLD: prdata = APB_DATA_W'(r_level_threshold);
            REG_INITIAL_DIT:     prdata = APB_DATA_W'(r_initial_dit);
            default:             prdata = '0;
        endcase
    end

    // Reload the dit estimate alongside the register write
    assign cfg.level_threshold = r_level_threshold;
    assign cfg.initial_dit_us  = pwdata[DIT_CFG_W-1:0];
    assign cfg.dit_load        = cfg_wr && (paddr[2] == REG_INITIAL_DIT);

    // Decode the held item whenever the output register can take its result
    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    // Payload needs no reset: qualified by the valid flag
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_sample  <= s_tdata[SAMPLE_W-1:0];
            r_time_us <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
        end
    end

    amr_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (advance),
        .i_sample     (r_sample),
        .i_time_us    (r_time_us),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register: load a fresh character, drop the flag once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out.character};
    assign m_tuser  = {r_out.word_end, r_out.unknown};

endmodule

>>> rtl/core/amr_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_lookup
// Code to character table: two bits per symbol, first symbol highest.
// ----------------------------------------------------------------------------
module amr_lookup import amr_pkg::*; (
    input  logic [CODE_W-1:0] i_code,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_unknown
);

    always_comb begin
        o_unknown = 1'b0;
        case (i_code)
            16'h0007: o_character = 7'h61; // a
            16'h00D5: o_character = 7'h62; // b
            16'h00DD: o_character = 7'h63; // c
            16'h0035: o_character = 7'h64; // d
            16'h0001: o_character = 7'h65; // e
            16'h005D: o_character = 7'h66; // f
            16'h003D: o_character = 7'h67; // g
            16'h0055: o_character = 7'h68; // h
            16'h0005: o_character = 7'h69; // i
            16'h007F: o_character = 7'h6A; // j
            16'h0037: o_character = 7'h6B; // k
            16'h0075: o_character = 7'h6C; // l
            16'h000F: o_character = 7'h6D; // m
            16'h000D: o_character = 7'h6E; // n
            16'h003F: o_character = 7'h6F; // o
            16'h007D: o_character = 7'h70; // p
            16'h00F7: o_character = 7'h71; // q
            16'h001D: o_character = 7'h72; // r
            16'h0015: o_character = 7'h73; // s
            16'h0003: o_character = 7'h74; // t
            16'h0017: o_character = 7'h75; // u
            16'h0057: o_character = 7'h76; // v
            16'h001F: o_character = 7'h77; // w
            16'h00D7: o_character = 7'h78; // x
            16'h00DF: o_character = 7'h79; // y
            16'h00F5: o_character = 7'h7A; // z
            16'h03FF: o_character = 7'h30; // 0
            16'h01FF: o_character = 7'h31; // 1
            16'h017F: o_character = 7'h32; // 2
            16'h015F: o_character = 7'h33; // 3
            16'h0157: o_character = 7'h34; // 4
            16'h0155: o_character = 7'h35; // 5
            16'h0355: o_character = 7'h36; // 6
            16'h03D5: o_character = 7'h37; // 7
            16'h03F5: o_character = 7'h38; // 8
            16'h03FD: o_character = 7'h39; // 9
            16'h0777: o_character = 7'h2E; // full stop
            16'h0F5F: o_character = 7'h2C; // comma
            16'h05F5: o_character = 7'h3F; // question mark
            16'h07FD: o_character = 7'h27; // apostrophe
            16'h0DDF: o_character = 7'h21; // exclamation mark
            16'h035D: o_character = 7'h2F; // slash
            16'h037D: o_character = 7'h28; // open bracket
            16'h0DF7: o_character = 7'h29; // close bracket
            16'h01D5: o_character = 7'h26; // ampersand
            16'h0FD5: o_character = 7'h3A; // colon
            16'h0DDD: o_character = 7'h3B; // semicolon
            16'h0357: o_character = 7'h3D; // equals
            16'h01DD: o_character = 7'h2B; // plus
            16'h0D57: o_character = 7'h2D; // hyphen
            16'h05F7: o_character = 7'h5F; // underscore
            16'h075D: o_character = 7'h22; // quote
            16'h15D7: o_character = 7'h24; // dollar
            16'h07DD: o_character = 7'h40; // at sign
            default: begin
                o_character = CHAR_SPACE;
                o_unknown   = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/amr_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_decoder
// Edge timing, symbol classification, dit tracking and character assembly.
// ----------------------------------------------------------------------------
module amr_decoder import amr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_item_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [TIME_W-1:0]   i_time_us,
    output logic                o_res_valid,
    output t_result             o_res
);

    logic                  r_prev_level, n_prev_level;
    logic [TIME_W-1:0]     r_last_change, n_last_change;
    logic [TIME_W-1:0]     r_dit, n_dit;
    logic [CODE_W-1:0]     r_code, n_code;
    logic                  r_prev_gap, n_prev_gap;
    logic [SYM_CNT_W-1:0]  r_sym_cnt, n_sym_cnt;
    logic [WORD_CNT_W-1:0] r_word_cnt, n_word_cnt;

    logic                  level;
    logic                  change;
    logic [TIME_W-1:0]     dur;
    logic [TIME_W:0]       dur_x;
    logic [TIME_W:0]       half_thirds;
    logic [TIME_W:0]       dit_x2;
    logic [TIME_W+2:0]     dit_x5;
    logic [TIME_W:0]       avg_sum;
    logic                  is_dit, is_dah, is_gap, is_end;
    logic [SYM_CNT_W-1:0]  sym_inc;
    logic [WORD_CNT_W-1:0] word_inc;
    logic [CODE_W-1:0]     end_code;
    logic [CHAR_W-1:0]     lk_char;
    logic                  lk_unknown;

    amr_lookup u_lookup (
        .i_code      (end_code),
        .o_character (lk_char),
        .o_unknown   (lk_unknown)
    );

    always_comb begin
        level       = i_sample > i_cfg.level_threshold;
        change      = i_item_valid && (level != r_prev_level);
        dur         = i_time_us - r_last_change;
        dur_x       = {1'b0, dur};
        half_thirds = {2'b00, r_dit[TIME_W-1:1]} + {1'b0, r_dit[TIME_W-1:1], 1'b0};
        dit_x2      = {r_dit, 1'b0};
        dit_x5      = {3'b000, r_dit} + {1'b0, r_dit, 2'b00};
        avg_sum     = {1'b0, r_dit} + dur_x;

        is_dit = r_prev_level && (dur > (r_dit >> 3)) && (dur_x <= half_thirds);
        is_dah = r_prev_level && (dur_x > half_thirds);
        is_gap = !r_prev_level && (dur > (r_dit >> 2)) && (dur_x <= dit_x2);
        is_end = !r_prev_level && (dur_x > dit_x2);

        sym_inc  = r_sym_cnt + 1'b1;
        word_inc = r_word_cnt + 1'b1;
        // a trailing gap has already shifted the code: undo it
        end_code = r_prev_gap ? (r_code >> 2) : r_code;

        n_prev_level  = r_prev_level;
        n_last_change = r_last_change;
        n_dit         = r_dit;
        n_code        = r_code;
        n_prev_gap    = r_prev_gap;
        n_sym_cnt     = r_sym_cnt;
        n_word_cnt    = r_word_cnt;

        o_res_valid      = 1'b0;
        o_res.character  = lk_char;
        o_res.unknown    = lk_unknown;
        o_res.word_end   = 1'b0;

        if (change) begin
            n_prev_level  = level;
            n_last_change = i_time_us;

            if (is_dit || is_dah || is_gap) begin
                if (is_gap) begin
                    if (!r_prev_gap) begin
                        n_code = r_code << 2;
                    end
                    n_prev_gap = 1'b1;
                end else begin
                    // a dit straight after a mark still reads as dah bits
                    if (is_dit && r_prev_gap) begin
                        n_code = r_code | CODE_W'(2'b01);
                    end else begin
                        n_code = r_code | CODE_W'(2'b11);
                    end
                    n_prev_gap = 1'b0;
                end
                n_sym_cnt = sym_inc;
                if (sym_inc > SYM_CNT_W'(SYMBOL_LIMIT)) begin
                    n_code     = '0;
                    n_prev_gap = 1'b1;
                    n_sym_cnt  = '0;
                end
                if (is_dit || is_gap) begin
                    n_dit = avg_sum[TIME_W:1];
                end
            end else if (is_end) begin
                n_code      = '0;
                n_prev_gap  = 1'b1;
                n_sym_cnt   = '0;
                n_word_cnt  = word_inc;
                o_res_valid = 1'b1;
                if (({2'b00, dur_x} > dit_x5) || (word_inc > WORD_CNT_W'(WORD_LIMIT))) begin
                    o_res.word_end = 1'b1;
                    n_word_cnt     = '0;
                end
            end
        end

        if (i_cfg.dit_load) begin
            n_dit = TIME_W'(i_cfg.initial_dit_us);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b0;
            r_last_change <= '0;
            r_dit         <= TIME_W'(INITIAL_DIT_RST);
            r_code        <= '0;
            r_prev_gap    <= 1'b1;
            r_sym_cnt     <= '0;
            r_word_cnt    <= '0;
        end else begin
            r_prev_level  <= n_prev_level;
            r_last_change <= n_last_change;
            r_dit         <= n_dit;
            r_code        <= n_code;
            r_prev_gap    <= n_prev_gap;
            r_sym_cnt     <= n_sym_cnt;
            r_word_cnt    <= n_word_cnt;
        end
    end

endmodule
